/* hdl/sots_pkg.sv */
// Shared types and constants of the second-order plant step block.
package sots_pkg;

  localparam int DT_BITS     = 24;
  localparam int DT_SHIFT    = DT_BITS + 1;
  localparam int MUL_CHUNK   = 32;
  localparam int CHUNK_IDX_W = 1;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_POSITION = 2'd0,
    REG_COEF_VELOCITY = 2'd1,
    REG_COEF_INPUT    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PS_INPUT = 3'd0,
    PS_POS   = 3'd1,
    PS_VEL   = 3'd2,
    PS_DTA   = 3'd3,
    PS_DTV   = 3'd4
  } prod_sel_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_SAT_A = 8'b0000_1000,
    ST_SUM_A = 8'b0001_0000,
    ST_SAT_V = 8'b0010_0000,
    ST_SUM_V = 8'b0100_0000,
    ST_SAT_P = 8'b1000_0000
  } sots_state_t;

  typedef struct packed {
    logic                   capture;
    logic                   mul_en;
    prod_sel_t              sel;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   clear;
    logic                   sub;
    logic                   sat_a;
    logic                   sum_a;
    logic                   sat_v;
    logic                   sum_v;
    logic                   sat_p;
  } sots_cmd_t;

endpackage

/* hdl/sots_if.sv */
// Request channel interfaces for the drive input and the position result.
interface sots_in_if import sots_pkg::*; #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic [DT_BITS-1:0]           step_time;

  modport source (output valid, output drive, output step_time, input ready);
  modport sink   (input valid, input drive, input step_time, output ready);
endinterface

interface sots_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] position;
  logic                         saturated;

  modport source (output valid, output position, output saturated, input ready);
  modport sink   (input valid, input position, input saturated, output ready);
endinterface

/* hdl/sots_ctrl.sv */
// Sequencer that steps the datapath through products, saturation and state update.
module sots_ctrl import sots_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sots_cmd_t cmd
);

  localparam int B_BITS = (DATA_WIDTH > DT_BITS + 1) ? DATA_WIDTH : DT_BITS + 1;
  localparam int NCH    = (B_BITS + MUL_CHUNK - 1) / MUL_CHUNK;

  sots_state_t            state_r, state_nxt;
  prod_sel_t              sel_r, sel_nxt;
  logic [CHUNK_IDX_W-1:0] chk_r, chk_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   last_chk;

  assign last_chk  = (chk_r == CHUNK_IDX_W'(NCH - 1));
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    chk_nxt       = chk_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.chunk     = chk_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          sel_nxt     = PS_INPUT;
          chk_nxt     = '0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.clear  = (chk_r == '0) && (sel_r == PS_INPUT || sel_r == PS_DTA ||
                                       sel_r == PS_DTV);
        cmd.sub    = (sel_r == PS_POS) || (sel_r == PS_VEL);
        if (last_chk) begin
          chk_nxt = '0;
          case (sel_r)
            PS_INPUT: sel_nxt   = PS_POS;
            PS_POS:   sel_nxt   = PS_VEL;
            default:  state_nxt = ST_DRAIN;
          endcase
        end else begin
          chk_nxt = chk_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        case (sel_r)
          PS_VEL:  state_nxt = ST_SAT_A;
          PS_DTA:  state_nxt = ST_SAT_V;
          default: state_nxt = ST_SAT_P;
        endcase
      end
      ST_SAT_A: begin
        cmd.sat_a = 1'b1;
        state_nxt = ST_SUM_A;
      end
      ST_SUM_A: begin
        cmd.sum_a = 1'b1;
        sel_nxt   = PS_DTA;
        state_nxt = ST_MUL;
      end
      ST_SAT_V: begin
        cmd.sat_v = 1'b1;
        state_nxt = ST_SUM_V;
      end
      ST_SUM_V: begin
        cmd.sum_v = 1'b1;
        sel_nxt   = PS_DTV;
        state_nxt = ST_MUL;
      end
      ST_SAT_P: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.sat_p     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= PS_INPUT;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/sots_dpath.sv */
// Datapath: coefficients, plant state, shared chunked multiplier and accumulator.
module sots_dpath import sots_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sots_cmd_t                    cmd,
  input  logic signed [DATA_WIDTH-1:0] in_drive,
  input  logic [DT_BITS-1:0]           in_step_time,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata,
  output logic signed [DATA_WIDTH-1:0] out_position,
  output logic                         out_saturated
);

  localparam int W      = DATA_WIDTH;
  localparam int SUM_W  = W + 1;
  localparam int B_BITS = (W > DT_BITS + 1) ? W : DT_BITS + 1;
  localparam int NCH    = (B_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BPAD   = NCH * MUL_CHUNK;
  localparam int PROD_W = SUM_W + MUL_CHUNK + 1;
  localparam int ACC_W  = W + BPAD + 3;

  logic signed [W-1:0]     coef_pos_r, coef_vel_r, coef_in_r;
  logic signed [W-1:0]     pos_r, vel_r, prev_r, tmp_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [W-1:0]     drive_r;
  logic [DT_BITS-1:0]      dt_r;
  logic                    sat_flag_r;
  logic signed [W-1:0]     out_pos_r;
  logic                    out_sat_r;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r, prod_sub_r, prod_clr_r;
  logic [CHUNK_IDX_W-1:0]   prod_chk_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [SUM_W-1:0]     a_sel;
  logic signed [BPAD-1:0]      b_sel;
  logic [MUL_CHUNK-1:0]        b_chunk;
  logic signed [MUL_CHUNK:0]   b_chunk_s;
  logic                        b_ext;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [ACC_W-1:0]     term, acc_base, acc_nxt;
  logic signed [ACC_W-1:0]     fin_val;
  logic [W:0]                  fin_sat;

  function automatic logic [W:0] sat_w(input logic signed [ACC_W-1:0] x);
    logic          ovf;
    logic [W-1:0]  v;
    ovf = (x[ACC_W-1:W-1] != {(ACC_W-W+1){x[ACC_W-1]}});
    if (ovf) begin
      v = x[ACC_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      v = x[W-1:0];
    end
    return {ovf, v};
  endfunction

  always_comb begin
    case (cmd.sel)
      PS_INPUT: a_sel = SUM_W'(coef_in_r);
      PS_POS:   a_sel = SUM_W'(coef_pos_r);
      PS_VEL:   a_sel = SUM_W'(coef_vel_r);
      default:  a_sel = sum_r;
    endcase
    case (cmd.sel)
      PS_INPUT: b_sel = BPAD'(drive_r);
      PS_POS:   b_sel = BPAD'(pos_r);
      PS_VEL:   b_sel = BPAD'(vel_r);
      default:  b_sel = signed'(BPAD'(dt_r));
    endcase
  end

  assign b_chunk   = b_sel[int'(cmd.chunk) * MUL_CHUNK +: MUL_CHUNK];
  assign b_ext     = (cmd.chunk == CHUNK_IDX_W'(NCH - 1)) & b_chunk[MUL_CHUNK-1];
  assign b_chunk_s = signed'({b_ext, b_chunk});
  assign prod_nxt  = a_sel * b_chunk_s;

  assign term     = ACC_W'(prod_r) <<< (int'(prod_chk_r) * MUL_CHUNK);
  assign acc_base = prod_clr_r ? '0 : acc_r;
  assign acc_nxt  = prod_sub_r ? acc_base - term : acc_base + term;

  always_comb begin
    if (cmd.sat_a) begin
      fin_val = acc_r >>> FRAC_BITS;
    end else if (cmd.sat_v) begin
      fin_val = ACC_W'(vel_r) + (acc_r >>> DT_SHIFT);
    end else begin
      fin_val = ACC_W'(pos_r) + (acc_r >>> DT_SHIFT);
    end
  end

  assign fin_sat = sat_w(fin_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_pos_r <= '0;
      coef_vel_r <= '0;
      coef_in_r  <= {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
      pos_r      <= '0;
      vel_r      <= '0;
      prev_r     <= '0;
      sat_flag_r <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COEF_POSITION: coef_pos_r <= cfg_wdata;
          REG_COEF_VELOCITY: coef_vel_r <= cfg_wdata;
          REG_COEF_INPUT:    coef_in_r  <= cfg_wdata;
          default: ;
        endcase
      end
      prod_vld_r <= cmd.mul_en;
      if (cmd.capture) begin
        sat_flag_r <= 1'b0;
      end else if (cmd.sat_a || cmd.sat_v) begin
        sat_flag_r <= sat_flag_r | fin_sat[W];
      end
      if (cmd.sum_a) begin
        prev_r <= tmp_r;
      end
      if (cmd.sum_v) begin
        vel_r <= tmp_r;
      end
      if (cmd.sat_p) begin
        pos_r <= fin_sat[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      drive_r <= in_drive;
      dt_r    <= in_step_time;
    end
    if (cmd.mul_en) begin
      prod_r     <= prod_nxt;
      prod_sub_r <= cmd.sub;
      prod_clr_r <= cmd.clear;
      prod_chk_r <= cmd.chunk;
    end
    if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.sat_a || cmd.sat_v) begin
      tmp_r <= fin_sat[W-1:0];
    end
    if (cmd.sum_a) begin
      sum_r <= SUM_W'(prev_r) + SUM_W'(tmp_r);
    end
    if (cmd.sum_v) begin
      sum_r <= SUM_W'(vel_r) + SUM_W'(tmp_r);
    end
    if (cmd.sat_p) begin
      out_pos_r <= fin_sat[W-1:0];
      out_sat_r <= sat_flag_r | fin_sat[W];
    end
  end

  assign out_position  = out_pos_r;
  assign out_saturated = out_sat_r;

endmodule

/* hdl/second_order_system_trapezoid_step.sv */
// Top level of the second-order plant step block with trapezoid integration.
//
// Each request on in_chan carries a drive value (signed fixed point) and the
// elapsed step time (unsigned Q0.24). The block forms the acceleration from
// the drive and the fed-back position and velocity, integrates velocity and
// position with the trapezoid rule, and returns one request on out_chan with
// the new position and a flag that is set when any value was clamped.
// The coefficients are to be written by the user through the cfg_ port only
// while the block idles; the block itself does not enforce this. An index
// beyond the three registers is dropped. One item is worked at a time. The
// five products run one slice a cycle through a single shared multiplier;
// the slices are the 32-bit parts of the sliced multiplier operand (one
// slice at DATA_WIDTH up to 32). in_chan is ready again once the result is
// registered, so the next item is accepted while the result still waits to
// be taken; if out_chan stalls, the following item holds before it writes
// its new position.
// Reset clears position, velocity and the previous acceleration, sets the
// input gain to one and the other gains to zero.
module second_order_system_trapezoid_step import sots_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sots_in_if.sink               in_chan,
  sots_out_if.source            out_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_wdata
);

  sots_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  sots_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_chan.ready),
    .cmd      (cmd)
  );

  sots_dpath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_drive     (in_chan.drive),
    .in_step_time (in_chan.step_time),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_position (out_chan.position),
    .out_saturated(out_chan.saturated)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (in_chan.valid && in_ready))
    else $error("item captured without an accepted request");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sat_p |-> (!out_valid || out_chan.ready))
    else $error("result written over a pending request");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sat_p |=> out_valid)
    else $error("finished result not presented");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.mul_en, cmd.sat_a, cmd.sum_a, cmd.sat_v,
              cmd.sum_v, cmd.sat_p}))
    else $error("more than one datapath command in a cycle");

endmodule
